// ===== rtl/core/generational_slot_allocator_top_assert.svh =====
// Assertion macros for the slot allocator.
// Every check is sampled on the rising edge of clk and is off while rst_n is low.
`ifndef GENERATIONAL_SLOT_ALLOCATOR_TOP_ASSERT_SVH
`define GENERATIONAL_SLOT_ALLOCATOR_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// The condition holds at every clock edge.
`define GSA_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("slot allocator check failed");

// When ante holds, cons holds on the same edge.
`define GSA_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("slot allocator check failed");

`else

`define GSA_ASSERT_ALWAYS(lbl, cond)
`define GSA_ASSERT_IMPLY(lbl, ante, cons)

`endif

`endif

// ===== rtl/core/gsa_pkg.sv =====
`default_nettype none
package gsa_pkg;

  // Default sizing
  localparam int SLOTS_DEF    = 64;
  localparam int GEN_BITS_DEF = 16;

  // Request codes
  localparam logic [1:0] MODE_ALLOC   = 2'd0;
  localparam logic [1:0] MODE_RELEASE = 2'd1;
  localparam logic [1:0] MODE_QUERY   = 2'd2;
  localparam logic [1:0] MODE_FLUSH   = 2'd3;

  // Result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_ALIVE = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_NULL      = 2'd3;

endpackage
`default_nettype wire

// ===== rtl/core/generational_slot_allocator_top.sv =====
`default_nettype none
// Channel   Ports                                                    Role
// in        in_valid, in_stall, in_mode, in_slot_index,              request beat
//           in_handle_gen, in_defer_free, in_entry_present
// out       out_valid, out_stall, out_status, out_index,             result beat
//           out_gen, out_is_alive
//
// Allocate from a fresh slot, or a rejected allocate: straight to the result.
// Allocate from the free stack: a stack read, then a generation read.
// Release: one generation read-modify-write. Query: one generation read.
// A flush, or a release that is not deferred, adds a pending scan over the used
// slots, one slot a cycle. This scan sets the worst case.
// Reset clears the alive and pending bits, the counters and the control state. The
// generation and stack memories need no clearing pass.
// One request is worked on at a time. in_stall is high while it is busy. A result
// held by out_stall does not block the next request, which waits only to hand over
// its own result.
`include "generational_slot_allocator_top_assert.svh"

module generational_slot_allocator_top #(
  parameter int SLOTS    = gsa_pkg::SLOTS_DEF,
  parameter int GEN_BITS = gsa_pkg::GEN_BITS_DEF,
  localparam int IDX_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1,
  localparam int CNT_W   = $clog2(SLOTS + 1)
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  // request channel
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [1:0]          in_mode,
  input  wire logic [IDX_W-1:0]    in_slot_index,
  input  wire logic [GEN_BITS-1:0] in_handle_gen,
  input  wire logic                in_defer_free,
  input  wire logic                in_entry_present,
  // result channel
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [1:0]               out_status,
  output logic [IDX_W-1:0]         out_index,
  output logic [GEN_BITS-1:0]      out_gen,
  output logic                     out_is_alive
);

  // FSM codes
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_STK  = 3'd1;
  localparam logic [2:0] S_GEN  = 3'd2;
  localparam logic [2:0] S_SCAN = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  localparam logic [GEN_BITS-1:0] GEN_ONE = GEN_BITS'(1);

  // Memories
  logic [GEN_BITS-1:0] gen_mem [SLOTS];
  logic [IDX_W-1:0]    stk_mem [SLOTS];

  // Control and per-slot flags
  logic [2:0]          state_r, state_nxt;
  logic [SLOTS-1:0]    alive_r, alive_nxt;
  logic [SLOTS-1:0]    pending_r, pending_nxt;
  logic [CNT_W-1:0]    free_cnt_r, free_cnt_nxt;
  logic [CNT_W-1:0]    used_r, used_nxt;
  logic [CNT_W-1:0]    scan_ptr_r, scan_ptr_nxt;

  // Request held during the work
  logic [1:0]          op_r, op_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic [GEN_BITS-1:0] hgen_r, hgen_nxt;
  logic                defer_r, defer_nxt;

  // Result held until the output register is free
  logic [1:0]          res_status_r, res_status_nxt;
  logic [IDX_W-1:0]    res_index_r, res_index_nxt;
  logic [GEN_BITS-1:0] res_gen_r, res_gen_nxt;
  logic                res_alive_r, res_alive_nxt;

  // Output register
  logic                out_valid_r;
  logic [1:0]          out_status_r;
  logic [IDX_W-1:0]    out_index_r;
  logic [GEN_BITS-1:0] out_gen_r;
  logic                out_alive_r;

  // Memory ports
  logic                gen_we;
  logic [IDX_W-1:0]    gen_waddr;
  logic [GEN_BITS-1:0] gen_wdata;
  logic [IDX_W-1:0]    gen_raddr;
  logic [GEN_BITS-1:0] gen_rd_r;
  logic                stk_we;
  logic [IDX_W-1:0]    stk_waddr;
  logic [IDX_W-1:0]    stk_wdata;
  logic [IDX_W-1:0]    stk_raddr;
  logic [IDX_W-1:0]    stk_rd_r;

  logic                in_fire;
  logic                out_free;
  logic                hit;
  logic [GEN_BITS-1:0] gen_inc;
  logic [IDX_W-1:0]    scan_idx;

  assign in_stall  = (state_r != S_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign scan_idx  = scan_ptr_r[IDX_W-1:0];

  // Handle check on the generation read back
  assign hit = (CNT_W'(idx_r) < used_r) && alive_r[idx_r] && (gen_rd_r == hgen_r);

  // Next generation, skipping zero on wrap
  always_comb begin
    gen_inc = gen_rd_r + GEN_ONE;
    if (gen_inc == '0) begin
      gen_inc = GEN_ONE;
    end
  end

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    alive_nxt      = alive_r;
    pending_nxt    = pending_r;
    free_cnt_nxt   = free_cnt_r;
    used_nxt       = used_r;
    scan_ptr_nxt   = scan_ptr_r;
    op_nxt         = op_r;
    idx_nxt        = idx_r;
    hgen_nxt       = hgen_r;
    defer_nxt      = defer_r;
    res_status_nxt = res_status_r;
    res_index_nxt  = res_index_r;
    res_gen_nxt    = res_gen_r;
    res_alive_nxt  = res_alive_r;
    gen_we         = 1'b0;
    gen_waddr      = idx_r;
    gen_wdata      = gen_inc;
    gen_raddr      = in_slot_index;
    stk_we         = 1'b0;
    stk_waddr      = free_cnt_r[IDX_W-1:0];
    stk_wdata      = scan_idx;
    stk_raddr      = IDX_W'(free_cnt_r - CNT_W'(1));

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          op_nxt         = in_mode;
          idx_nxt        = in_slot_index;
          hgen_nxt       = in_handle_gen;
          defer_nxt      = in_defer_free;
          res_status_nxt = gsa_pkg::ST_OK;
          res_index_nxt  = '0;
          res_gen_nxt    = '0;
          res_alive_nxt  = 1'b0;
          scan_ptr_nxt   = '0;
          case (in_mode)
            gsa_pkg::MODE_ALLOC: begin
              if (!in_entry_present) begin
                res_status_nxt = gsa_pkg::ST_NULL;
                state_nxt      = S_DONE;
              end else if (free_cnt_r != '0) begin
                // pop the stack top; its data comes back next cycle
                free_cnt_nxt = free_cnt_r - CNT_W'(1);
                state_nxt    = S_STK;
              end else if (used_r < CNT_W'(SLOTS)) begin
                // fresh slot starts at generation one
                gen_we                         = 1'b1;
                gen_waddr                      = used_r[IDX_W-1:0];
                gen_wdata                      = GEN_ONE;
                alive_nxt[used_r[IDX_W-1:0]]   = 1'b1;
                pending_nxt[used_r[IDX_W-1:0]] = 1'b0;
                used_nxt                       = used_r + CNT_W'(1);
                res_index_nxt                  = used_r[IDX_W-1:0];
                res_gen_nxt                    = GEN_ONE;
                state_nxt                      = S_DONE;
              end else begin
                res_status_nxt = gsa_pkg::ST_FULL;
                state_nxt      = S_DONE;
              end
            end
            gsa_pkg::MODE_RELEASE, gsa_pkg::MODE_QUERY: begin
              state_nxt = S_GEN;
            end
            default: begin
              state_nxt = S_SCAN;
            end
          endcase
        end
      end

      S_STK: begin
        // popped slot known; fetch its generation
        idx_nxt   = stk_rd_r;
        gen_raddr = stk_rd_r;
        state_nxt = S_GEN;
      end

      S_GEN: begin
        case (op_r)
          gsa_pkg::MODE_ALLOC: begin
            alive_nxt[idx_r]   = 1'b1;
            pending_nxt[idx_r] = 1'b0;
            res_index_nxt      = idx_r;
            res_gen_nxt        = gen_rd_r;
            state_nxt          = S_DONE;
          end
          gsa_pkg::MODE_RELEASE: begin
            if (hit) begin
              gen_we             = 1'b1;
              alive_nxt[idx_r]   = 1'b0;
              pending_nxt[idx_r] = 1'b1;
              res_alive_nxt      = 1'b1;
              state_nxt          = defer_r ? S_DONE : S_SCAN;
            end else begin
              res_status_nxt = gsa_pkg::ST_NOT_ALIVE;
              state_nxt      = S_DONE;
            end
          end
          default: begin
            res_alive_nxt = hit;
            state_nxt     = S_DONE;
          end
        endcase
      end

      S_SCAN: begin
        // one slot a cycle, ascending, pending slots go onto the stack
        if (scan_ptr_r >= used_r) begin
          state_nxt = S_DONE;
        end else begin
          if (pending_r[scan_idx]) begin
            pending_nxt[scan_idx] = 1'b0;
            if (free_cnt_r < CNT_W'(SLOTS)) begin
              stk_we       = 1'b1;
              free_cnt_nxt = free_cnt_r + CNT_W'(1);
            end
          end
          scan_ptr_nxt = scan_ptr_r + CNT_W'(1);
        end
      end

      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      alive_r     <= '0;
      pending_r   <= '0;
      free_cnt_r  <= '0;
      used_r      <= '0;
      scan_ptr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      alive_r    <= alive_nxt;
      pending_r  <= pending_nxt;
      free_cnt_r <= free_cnt_nxt;
      used_r     <= used_nxt;
      scan_ptr_r <= scan_ptr_nxt;
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    idx_r        <= idx_nxt;
    hgen_r       <= hgen_nxt;
    defer_r      <= defer_nxt;
    res_status_r <= res_status_nxt;
    res_index_r  <= res_index_nxt;
    res_gen_r    <= res_gen_nxt;
    res_alive_r  <= res_alive_nxt;
    if (state_r == S_DONE && out_free) begin
      out_status_r <= res_status_r;
      out_index_r  <= res_index_r;
      out_gen_r    <= res_gen_r;
      out_alive_r  <= res_alive_r;
    end
  end

  // Generation memory
  always_ff @(posedge clk) begin
    if (gen_we) begin
      gen_mem[gen_waddr] <= gen_wdata;
    end
    gen_rd_r <= gen_mem[gen_raddr];
  end

  // Free stack memory
  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
    stk_rd_r <= stk_mem[stk_raddr];
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_index    = out_index_r;
  assign out_gen      = out_gen_r;
  assign out_is_alive = out_alive_r;

  // Checks
  `GSA_ASSERT_ALWAYS(a_free_le_used, free_cnt_r <= used_r)
  `GSA_ASSERT_ALWAYS(a_alive_pending_excl, (alive_r & pending_r) == '0)
  `GSA_ASSERT_IMPLY(a_gen_nonzero, gen_we, gen_wdata != '0)
  `GSA_ASSERT_IMPLY(a_scan_bound, state_r == S_SCAN, scan_ptr_r <= used_r)

endmodule
`default_nettype wire

// ===== verif/generational_slot_allocator_top_tb.sv =====
`timescale 1ns / 1ps

module generational_slot_allocator_top_tb;

  localparam int SLOTS        = gsa_pkg::SLOTS_DEF;
  localparam int GEN_W        = gsa_pkg::GEN_BITS_DEF;
  localparam int IDX_W        = $clog2(SLOTS);
  localparam int RANDOM_ITEMS = 1528;
  localparam int LONG_HOLD    = 300;
  localparam int CYCLE_LIMIT  = 1000000;

  typedef struct packed {
    logic [1:0]       status;
    logic [IDX_W-1:0] index;
    logic [GEN_W-1:0] gen;
    logic             alive;
  } slot_result_t;

  // Tracks the slot map and the queue of results it predicts
  class slot_map_scoreboard;
    bit                 alive[SLOTS];
    bit                 pending[SLOTS];
    logic [GEN_W-1:0]   slot_gen[SLOTS];
    logic [IDX_W-1:0]   free_stack[SLOTS];
    int                 free_count;
    int                 used_slots;
    slot_result_t       expected_q[$];
    int                 errors;

    function new();
      foreach (alive[i]) begin
        alive[i]    = 1'b0;
        pending[i]  = 1'b0;
        slot_gen[i] = '0;
      end
      free_count = 0;
      used_slots = 0;
      errors     = 0;
    endfunction

    function bit handle_ok(logic [IDX_W-1:0] idx, logic [GEN_W-1:0] hg);
      return (idx < used_slots) && alive[idx] && (slot_gen[idx] == hg);
    endfunction

    // Pending slots go onto the stack in ascending order
    function void push_pending();
      for (int i = 0; i < used_slots; i++) begin
        if (pending[i]) begin
          pending[i] = 1'b0;
          if (free_count < SLOTS) begin
            free_stack[free_count] = IDX_W'(i);
            free_count++;
          end
        end
      end
    endfunction

    function int pick_live_slot();
      int live_q[$];
      foreach (alive[i])
        if (alive[i]) live_q.insert(live_q.size(), i);
      if (live_q.size() == 0) return -1;
      return live_q[$urandom_range(0, live_q.size() - 1)];
    endfunction

    // Apply one accepted request beat and queue its result
    function void note_request(logic [1:0] mode, logic [IDX_W-1:0] idx,
                               logic [GEN_W-1:0] hg, logic defer, logic present);
      slot_result_t     r;
      int               s;
      bit               got;
      logic [GEN_W-1:0] ng;
      r   = '0;
      got = 1'b0;
      s   = 0;
      case (mode)
        gsa_pkg::MODE_ALLOC: begin
          if (!present) begin
            r.status = gsa_pkg::ST_NULL;
          end else if (free_count > 0) begin
            free_count--;
            s   = free_stack[free_count];
            got = 1'b1;
          end else if (used_slots < SLOTS) begin
            s           = used_slots;
            used_slots++;
            slot_gen[s] = GEN_W'(1);
            got         = 1'b1;
          end else begin
            r.status = gsa_pkg::ST_FULL;
          end
          if (got) begin
            alive[s]   = 1'b1;
            pending[s] = 1'b0;
            r.index    = IDX_W'(s);
            r.gen      = slot_gen[s];
          end
        end
        gsa_pkg::MODE_RELEASE: begin
          if (!handle_ok(idx, hg)) begin
            r.status = gsa_pkg::ST_NOT_ALIVE;
          end else begin
            // generation skips zero on wrap
            ng = slot_gen[idx] + 1'b1;
            if (ng == '0) ng = GEN_W'(1);
            slot_gen[idx] = ng;
            alive[idx]    = 1'b0;
            pending[idx]  = 1'b1;
            if (!defer) push_pending();
            r.alive = 1'b1;
          end
        end
        gsa_pkg::MODE_QUERY: r.alive = handle_ok(idx, hg);
        default: push_pending();
      endcase
      expected_q.insert(expected_q.size(), r);
    endfunction

    function void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
        $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(logic [1:0] status, logic [IDX_W-1:0] index,
                               logic [GEN_W-1:0] gen, logic is_alive);
      slot_result_t e;
      if (expected_q.size() == 0) begin
        $display("%0t: result beat with nothing expected: status %0h index %0h gen %0h",
                 $time, status, index, gen);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      compare_field("status", e.status, status);
      compare_field("out_index", e.index, index);
      compare_field("out_gen", e.gen, gen);
      compare_field("is_alive", e.alive, is_alive);
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  logic [1:0]       in_mode;
  logic [IDX_W-1:0] in_slot_index;
  logic [GEN_W-1:0] in_handle_gen;
  logic             in_defer_free;
  logic             in_entry_present;
  logic             out_valid;
  logic             out_stall;
  logic [1:0]       out_status;
  logic [IDX_W-1:0] out_index;
  logic [GEN_W-1:0] out_gen;
  logic             out_is_alive;

  slot_map_scoreboard sb = new();
  int requests_seen = 0;

  generational_slot_allocator_top u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_mode          (in_mode),
    .in_slot_index    (in_slot_index),
    .in_handle_gen    (in_handle_gen),
    .in_defer_free    (in_defer_free),
    .in_entry_present (in_entry_present),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_index        (out_index),
    .out_gen          (out_gen),
    .out_is_alive     (out_is_alive)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Sample both channels at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        sb.note_request(in_mode, in_slot_index, in_handle_gen, in_defer_free,
                        in_entry_present);
        requests_seen++;
      end
      if (out_valid && !out_stall)
        sb.check_result(out_status, out_index, out_gen, out_is_alive);
    end
  end

  // Hold a request beat until it is taken
  task automatic drive_beat(logic [1:0] m, logic [IDX_W-1:0] idx, logic [GEN_W-1:0] hg,
                            logic defer, logic present);
    in_valid         <= 1'b1;
    in_mode          <= m;
    in_slot_index    <= idx;
    in_handle_gen    <= hg;
    in_defer_free    <= defer;
    in_entry_present <= present;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic issue(logic [1:0] m, logic [IDX_W-1:0] idx, logic [GEN_W-1:0] hg,
                       logic defer, logic present);
    @(negedge clk);
    drive_beat(m, idx, hg, defer, present);
  endtask

  task automatic idle_gap(int cycles);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  // Mostly well-formed handles taken from the live set, the rest stale or random
  task automatic issue_random(int alloc_pct);
    int               r;
    int               k;
    int               live;
    int               rel_lim;
    logic [1:0]       m;
    logic [IDX_W-1:0] idx;
    logic [GEN_W-1:0] hg;
    logic             defer;
    logic             present;
    @(negedge clk);
    r       = $urandom_range(0, 99);
    idx     = IDX_W'($urandom);
    hg      = GEN_W'($urandom);
    defer   = 1'($urandom);
    present = 1'($urandom);
    rel_lim = alloc_pct + (95 - alloc_pct) * 6 / 10;
    if (r < alloc_pct) begin
      m       = gsa_pkg::MODE_ALLOC;
      present = ($urandom_range(0, 19) != 0);
    end else if (r < 95) begin
      m    = (r < rel_lim) ? gsa_pkg::MODE_RELEASE : gsa_pkg::MODE_QUERY;
      k    = $urandom_range(0, 9);
      live = sb.pick_live_slot();
      if (live >= 0 && k < 8) begin
        idx = IDX_W'(live);
        hg  = sb.slot_gen[live];
        if (k == 7) hg = hg - 1'b1;
      end else if (k == 8 && sb.used_slots > 0) begin
        // right generation, slot may be dead or pending
        idx = IDX_W'($urandom_range(0, sb.used_slots - 1));
        hg  = sb.slot_gen[idx];
      end
    end else begin
      m = gsa_pkg::MODE_FLUSH;
    end
    drive_beat(m, idx, hg, defer, present);
  endtask

  // Receiver stall pattern, with one long hold-off to back up the request side
  initial begin
    int  style;
    int  span;
    int  tick;
    bit  held;
    out_stall = 1'b0;
    tick      = 0;
    held      = 1'b0;
    forever begin
      style = $urandom_range(0, 3);
      span  = $urandom_range(20, 200);
      repeat (span) begin
        @(negedge clk);
        tick++;
        if (!held && requests_seen >= 400) begin
          out_stall <= 1'b1;
          repeat (LONG_HOLD) @(negedge clk);
          held = 1'b1;
        end
        case (style)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 99) < 30);
          2: out_stall <= ($urandom_range(0, 99) < 75);
          default: out_stall <= (tick % 4 == 0);
        endcase
      end
    end
  end

  // Run limit
  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin
    int sent;
    int burst;
    int pct;
    in_valid         = 1'b0;
    in_mode          = gsa_pkg::MODE_ALLOC;
    in_slot_index    = '0;
    in_handle_gen    = '0;
    in_defer_free    = 1'b0;
    in_entry_present = 1'b0;
    rst_n            = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty map, null entry, unknown handles, deferred and flushed frees
    issue(gsa_pkg::MODE_ALLOC,   0,  0,        0, 0);
    issue(gsa_pkg::MODE_RELEASE, 0,  1,        0, 1);
    issue(gsa_pkg::MODE_QUERY,   63, 16'hFFFF, 1, 1);
    issue(gsa_pkg::MODE_FLUSH,   0,  0,        0, 0);
    issue(gsa_pkg::MODE_ALLOC,   0,  0,        0, 1);
    issue(gsa_pkg::MODE_ALLOC,   0,  0,        0, 1);
    issue(gsa_pkg::MODE_ALLOC,   0,  0,        0, 1);
    issue(gsa_pkg::MODE_QUERY,   1,  1,        0, 0);
    issue(gsa_pkg::MODE_QUERY,   1,  2,        0, 0);
    issue(gsa_pkg::MODE_RELEASE, 0,  0,        0, 1);
    issue(gsa_pkg::MODE_RELEASE, 1,  1,        1, 1);
    issue(gsa_pkg::MODE_RELEASE, 1,  2,        1, 1);
    issue(gsa_pkg::MODE_QUERY,   1,  2,        0, 1);
    issue(gsa_pkg::MODE_RELEASE, 0,  1,        1, 0);
    issue(gsa_pkg::MODE_ALLOC,   0,  0,        0, 1);
    issue(gsa_pkg::MODE_FLUSH,   0,  0,        1, 1);
    issue(gsa_pkg::MODE_ALLOC,   0,  0,        0, 1);
    issue(gsa_pkg::MODE_ALLOC,   0,  0,        0, 1);
    issue(gsa_pkg::MODE_RELEASE, 2,  1,        0, 1);
    issue(gsa_pkg::MODE_FLUSH,   0,  0,        0, 0);
    issue(gsa_pkg::MODE_ALLOC,   0,  0,        0, 1);
    issue(gsa_pkg::MODE_ALLOC,   0,  0,        0, 0);
    idle_gap(4);

    // Random: the alloc share cycles through 85, 45 and 20 percent every 100 items
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      case ((sent / 100) % 3)
        0: pct = 85;
        1: pct = 45;
        default: pct = 20;
      endcase
      burst = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 10);
      repeat (burst) begin
        if (sent < RANDOM_ITEMS) begin
          issue_random(pct);
          sent++;
        end
      end
      idle_gap($urandom_range(1, 6));
    end

    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (SLOTS + 8) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
